[rtl/tilt_to_position_conditioner_defines.svh]
// assertion macros for the tilt-to-position conditioner
// expects signals clk and rst in the scope where a macro is used
`ifndef TILT_TO_POSITION_CONDITIONER_DEFINES_SVH
`define TILT_TO_POSITION_CONDITIONER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TTPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TTPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ttpc_pkg.sv]
// shared constants for the tilt-to-position conditioner
// no dependencies
`default_nettype none

package ttpc_pkg;

  // fixed register and field widths
  localparam int ALPHA_W    = 9;
  localparam int ALPHA_FRAC = 8;
  localparam int DZ_W       = 15;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_TILT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MAX   = 3'd6;

  // reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd64;
  localparam logic [DZ_W-1:0]    DEAD_ZONE_RST = 15'd100;
  localparam logic [DZ_W-1:0]    FULL_TILT_RST = 15'd1000;
  localparam logic [POS_W-1:0]   POS_MIN_RST   = 10'd0;
  localparam logic [POS_W-1:0]   POS_MAX_RST   = 10'd1023;

  // alpha of one, Q1.8
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

endpackage

`default_nettype wire

[rtl/tilt_to_position_conditioner.sv]
// tilt-to-position conditioner: bias, optional negation, ema filter, dead zone, linear map
// uses ttpc_pkg and tilt_to_position_conditioner_defines.svh
`default_nettype none
// usage
//   sample channel: sample_mg with sample_valid / sample_ready, one transfer
//   per accelerometer reading. position channel: position with
//   position_valid / position_ready, exactly one result per sample.
//   cfg_wr_en / cfg_index / cfg_wdata write one register per cycle, index
//   order bias, invert, alpha, dead zone, full tilt, pos min, pos max;
//   indexes past the list are ignored. write only while the block is idle.
// sequencing
//   one item at a time. the filter update uses a 9-step shift-add multiply
//   and the scaling a 10-step restoring divide; the first sample after
//   reset loads the filter without the multiply, and a filtered value in
//   the dead zone skips the divide. sample_ready rises on the same edge
//   as position_valid, so a new sample is taken once the last result is
//   loaded into the output register.
// reset
//   registers take their defaults, the filter is marked empty so the next
//   sample loads it directly, and no result is pending.
// stall
//   a finished position sits in the output register; a new sample is taken
//   meanwhile and its result waits in the last state until the register
//   frees up.

`include "tilt_to_position_conditioner_defines.svh"

module tilt_to_position_conditioner
  import ttpc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8,
  localparam int CFG_W = (SAMPLE_BITS > DZ_W) ? SAMPLE_BITS : DZ_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  // sample channel
  input  wire logic                          sample_valid,
  output logic                               sample_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_mg,
  // position channel
  output logic                               position_valid,
  input  wire logic                          position_ready,
  output logic [POS_W-1:0]                   position
);

  localparam int SB = SAMPLE_BITS;
  localparam int FB = FRAC_BITS;
  // filter state: value scaled by 2^FB
  localparam int FW = SB + FB;
  // alpha product: difference is FW+1 bits, alpha adds ALPHA_W
  localparam int PW = FW + 1 + ALPHA_W;
  // common width for comparing magnitude against dead zone
  localparam int CW = ((SB > DZ_W) ? SB : DZ_W) + 1;
  localparam int NW = DZ_W + POS_W;

  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(ALPHA_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(POS_W - 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PREP = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_FILT = 10'b0000001000,
    S_MAG  = 10'b0000010000,
    S_ZONE = 10'b0000100000,
    S_PROD = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [SB-1:0] bias_mg;
  logic                 invert;
  logic [ALPHA_W-1:0]   alpha_q8;
  logic [DZ_W-1:0]      dead_zone_mg;
  logic [DZ_W-1:0]      full_tilt_mg;
  logic [POS_W-1:0]     pos_min;
  logic [POS_W-1:0]     pos_max;

  // filter state
  logic signed [FW-1:0] filt;
  logic                 first_pending;

  // working registers
  logic signed [SB-1:0] x_val;
  logic signed [PW-1:0] mcand;
  logic signed [PW-1:0] acc;
  logic [ALPHA_W-1:0]   a_sh;
  logic [STEP_W-1:0]    step;
  logic [SB-1:0]        mag;
  logic                 m_neg;
  logic [POS_W-1:0]     centre;
  logic                 hneg;
  logic [POS_W-1:0]     absh;
  logic [DZ_W-1:0]      eff;
  logic [DZ_W-1:0]      dval;
  logic [DZ_W-1:0]      rem;
  logic [POS_W-1:0]     dq;
  logic [POS_W-1:0]     result;

  logic sample_xfer;
  logic out_load;

  assign sample_ready = (state == S_IDLE);
  assign sample_xfer  = sample_valid && sample_ready;
  assign out_load     = (state == S_OUT) && (!position_valid || position_ready);

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_mg      <= '0;
      invert       <= 1'b0;
      alpha_q8     <= ALPHA_RST;
      dead_zone_mg <= DEAD_ZONE_RST;
      full_tilt_mg <= FULL_TILT_RST;
      pos_min      <= POS_MIN_RST;
      pos_max      <= POS_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BIAS:      bias_mg      <= cfg_wdata[SB-1:0];
        REG_INVERT:    invert       <= cfg_wdata[0];
        REG_ALPHA:     alpha_q8     <= cfg_wdata[ALPHA_W-1:0];
        REG_DEAD_ZONE: dead_zone_mg <= cfg_wdata[DZ_W-1:0];
        REG_FULL_TILT: full_tilt_mg <= cfg_wdata[DZ_W-1:0];
        REG_POS_MIN:   pos_min      <= cfg_wdata[POS_W-1:0];
        REG_POS_MAX:   pos_max      <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath combinational ----------------
  // bias subtraction, saturated
  logic signed [SB:0]   diff;
  logic signed [SB-1:0] diff_sat;
  // optional negation, saturated, then scaled into filter format
  logic signed [SB-1:0] x_sel;
  logic signed [FW-1:0] x_scaled;
  logic [ALPHA_W-1:0]   a_eff;
  // filter update
  logic signed [FW+1:0] filt_sum;
  logic [FW-1:0]        filt_abs;
  // dead zone and range
  logic [CW-1:0]        mag_ext;
  logic [CW-1:0]        dz_ext;
  logic [CW-1:0]        d_raw;
  logic                 in_zone;
  logic [POS_W:0]       centre_sum;
  logic [POS_W-1:0]     centre_c;
  logic signed [POS_W:0] half;
  logic [POS_W:0]       half_abs;
  logic signed [DZ_W:0] eff_raw;
  logic [DZ_W-1:0]      eff_c;
  // product and divide step
  logic [NW-1:0]        prod;
  logic [DZ_W:0]        trial;
  logic [DZ_W+1:0]      trial_diff;
  logic                 trial_ge;
  // final placement
  logic signed [POS_W+1:0] off;
  logic signed [POS_W+1:0] p_raw;
  logic signed [POS_W+1:0] p_lo;
  logic [POS_W-1:0]        p_fin;

  always_comb begin
    diff = {sample_mg[SB-1], sample_mg} - {bias_mg[SB-1], bias_mg};
    if (diff[SB] != diff[SB-1]) begin
      diff_sat = diff[SB] ? SMIN : SMAX;
    end else begin
      diff_sat = diff[SB-1:0];
    end

    if (!invert) begin
      x_sel = x_val;
    end else if (x_val == SMIN) begin
      x_sel = SMAX;
    end else begin
      x_sel = -x_val;
    end
    x_scaled = {x_sel, {FB{1'b0}}};
    // alpha above one acts as one
    a_eff = alpha_q8[ALPHA_W-1] ? ALPHA_ONE : alpha_q8;

    // F + floor(a * (X - F) / 256)
    filt_sum = {{2{filt[FW-1]}}, filt} + acc[PW-1:ALPHA_FRAC];
    filt_abs = filt[FW-1] ? FW'(-filt) : FW'(filt);

    mag_ext = CW'(mag);
    dz_ext  = CW'(dead_zone_mg);
    in_zone = (mag_ext < dz_ext);
    d_raw   = mag_ext - dz_ext;

    centre_sum = {1'b0, pos_min} + {1'b0, pos_max};
    centre_c   = centre_sum[POS_W:1];
    half       = $signed({1'b0, pos_max}) - $signed({1'b0, centre_c});
    half_abs   = half[POS_W] ? (POS_W+1)'(-half) : (POS_W+1)'(half);

    // effective range, at least one
    eff_raw = $signed({1'b0, full_tilt_mg}) - $signed({1'b0, dead_zone_mg});
    if (eff_raw[DZ_W] || (eff_raw == '0)) begin
      eff_c = DZ_W'(1);
    end else begin
      eff_c = eff_raw[DZ_W-1:0];
    end

    prod = NW'(dval) * NW'(absh);

    // restoring divide step, remainder stays below eff
    trial      = {rem, dq[POS_W-1]};
    trial_diff = {1'b0, trial} - {2'b00, eff};
    trial_ge   = !trial_diff[DZ_W+1];

    off   = hneg ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
    p_raw = m_neg ? $signed({2'b00, centre}) - off : $signed({2'b00, centre}) + off;
    if (p_raw < $signed({2'b00, pos_min})) begin
      p_lo = $signed({2'b00, pos_min});
    end else begin
      p_lo = p_raw;
    end
    if (p_lo > $signed({2'b00, pos_max})) begin
      p_fin = pos_max;
    end else begin
      p_fin = p_lo[POS_W-1:0];
    end
  end

  // ---------------- sequencer and working registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_pending <= 1'b1;
      filt          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_xfer) begin
            x_val <= diff_sat;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (first_pending) begin
            // first sample loads the filter
            filt          <= x_scaled;
            first_pending <= 1'b0;
            state         <= S_MAG;
          end else begin
            mcand <= PW'(x_scaled) - PW'(filt);
            acc   <= '0;
            a_sh  <= a_eff;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // shift-add, one alpha bit per cycle
          if (a_sh[0]) begin
            acc <= acc + mcand;
          end
          mcand <= mcand <<< 1;
          a_sh  <= a_sh >> 1;
          step  <= step + 1'b1;
          if (step == MUL_LAST) begin
            state <= S_FILT;
          end
        end
        S_FILT: begin
          filt  <= filt_sum[FW-1:0];
          state <= S_MAG;
        end
        S_MAG: begin
          // magnitude truncated toward zero
          mag   <= filt_abs[FW-1:FB];
          m_neg <= filt[FW-1];
          state <= S_ZONE;
        end
        S_ZONE: begin
          centre <= centre_c;
          hneg   <= half[POS_W];
          absh   <= half_abs[POS_W-1:0];
          eff    <= eff_c;
          if (d_raw > CW'(eff_c)) begin
            dval <= eff_c;
          end else begin
            dval <= d_raw[DZ_W-1:0];
          end
          if (in_zone) begin
            result <= centre_c;
            state  <= S_OUT;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          rem   <= prod[NW-1:POS_W];
          dq    <= prod[POS_W-1:0];
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial_ge) begin
            rem <= trial_diff[DZ_W-1:0];
          end else begin
            rem <= trial[DZ_W-1:0];
          end
          dq   <= {dq[POS_W-2:0], trial_ge};
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          result <= p_fin;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      position_valid <= 1'b0;
    end else if (out_load) begin
      position_valid <= 1'b1;
    end else if (position_ready) begin
      position_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      position <= result;
    end
  end

  // ---------------- assertions ----------------
  `TTPC_ASSERT_NXT(a_busy_after_xfer, sample_xfer, !sample_ready, "ready after sample transfer")
  `TTPC_ASSERT_IMP(a_rem_below_eff, state == S_DIV, rem < eff, "divide remainder out of range")
  `TTPC_ASSERT_IMP(a_quot_bound, state == S_FIN, dq <= absh, "offset exceeds half range")

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking bench for tilt_to_position_conditioner: directed and random samples,
// predicted positions checked in order under random idling on both channels
// depends on ttpc_pkg and the rtl of tilt_to_position_conditioner
`timescale 1ns / 1ps

module tb;
  import ttpc_pkg::*;

  localparam int SMP_W       = 16;
  localparam int CFG_WIDTH   = (SMP_W > DZ_W) ? SMP_W : DZ_W;
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int SETTLE      = 30;   // margin after the last position, longer than a sample's full pass
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 117;

  // register index past the end of the list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_WIDTH-1:0]    cfg_wdata = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_ready;
  logic signed [SMP_W-1:0] sample_mg = '0;
  logic                    position_valid;
  logic                    position_ready = 1'b0;
  logic [POS_W-1:0]        position;

  tilt_to_position_conditioner uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample_mg(sample_mg),
    .position_valid(position_valid),
    .position_ready(position_ready),
    .position(position)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the registers and the filter state
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0] bias_r   = '0;
  logic                    inv_r    = 1'b0;
  logic [ALPHA_W-1:0]      alpha_r  = ALPHA_RST;
  logic [DZ_W-1:0]         dz_r     = DEAD_ZONE_RST;
  logic [DZ_W-1:0]         ft_r     = FULL_TILT_RST;
  logic [POS_W-1:0]        pmin_r   = POS_MIN_RST;
  logic [POS_W-1:0]        pmax_r   = POS_MAX_RST;
  logic signed [24:0]      ema_q8   = '0;    // filter state, Q16.8
  logic                    load_ema = 1'b1;  // next sample loads the filter

  // bench bookkeeping
  logic signed [SMP_W-1:0] pending_samples[$];  // waiting to be offered
  logic [POS_W-1:0]        want_pos[$];         // predicted positions, oldest first
  logic [POS_W-1:0]        want_now;
  int  queued_total = 0;
  int  accepted_cnt = 0;
  int  checked_cnt  = 0;
  int  fails        = 0;
  int  cfg_writes   = 0;
  int  phases_run   = 0;
  int  tilt_target  = 0;
  bit  calm         = 1'b0;  // no idling on either side while set
  bit  hold_req     = 1'b0;
  bit  sample_fired = 1'b0;  // sample transfer seen at the last rising edge
  bit  pos_fired    = 1'b0;  // position transfer seen at the last rising edge
  int  send_gap     = 0;
  int  recv_gap     = 0;
  int  hold_left    = 0;
  int  holds_done   = 0;
  logic                    drv_valid;
  logic signed [SMP_W-1:0] drv_data;
  logic                    nxt_ready;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // bias removal, optional negation, ema, dead zone and linear map;
  // advances the shadow filter state by one sample
  function automatic logic [POS_W-1:0] track_position(input logic signed [SMP_W-1:0] smp);
    longint x, a, acc, m, mag, c, h, eff, d, off, p;
    x = longint'(smp) - longint'(bias_r);
    if (x > 32767) x = 32767;
    else if (x < -32768) x = -32768;
    // negating the most negative value saturates to the top
    if (inv_r) begin
      x = -x;
      if (x > 32767) x = 32767;
    end
    if (load_ema) begin
      ema_q8   = x * 256;
      load_ema = 1'b0;
    end else begin
      // alpha above one acts as one
      a   = (alpha_r > ALPHA_ONE) ? 256 : longint'(alpha_r);
      acc = a * x * 256 + (256 - a) * longint'(ema_q8);
      ema_q8 = acc >>> 8;  // floor division
    end
    m   = longint'(ema_q8) / 256;  // truncates toward zero
    mag = (m < 0) ? -m : m;
    c   = (longint'(pmin_r) + longint'(pmax_r)) / 2;
    h   = longint'(pmax_r) - c;    // negative when min exceeds max by two or more
    if (mag < longint'(dz_r)) begin
      p = c;  // centre stays unclamped in the dead zone
    end else begin
      eff = longint'(ft_r) - longint'(dz_r);
      if (eff <= 0) eff = 1;
      d = mag - longint'(dz_r);
      if (d > eff) d = eff;
      off = (d * h) / eff;
      p = (m >= 0) ? c + off : c - off;
      if (p < longint'(pmin_r)) p = longint'(pmin_r);
      if (p > longint'(pmax_r)) p = longint'(pmax_r);
    end
    return p[POS_W-1:0];
  endfunction

  // random sample: most often a slowly wandering tilt, plus noise, extremes
  // and values aimed at the dead zone and full tilt edges
  function automatic logic signed [SMP_W-1:0] next_sample();
    int r, v, base, sgn;
    r    = $urandom_range(0, 99);
    base = int'(bias_r);
    sgn  = ($urandom_range(0, 1) != 0) ? 1 : -1;
    if (r < 45) begin
      tilt_target += int'($urandom_range(0, 600)) - 300;
      if (tilt_target > 5000) tilt_target = 5000;
      if (tilt_target < -5000) tilt_target = -5000;
      v = base + tilt_target + int'($urandom_range(0, 40)) - 20;
    end else if (r < 65) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else if (r < 75) begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end else if (r < 88) begin
      v = base + sgn * (int'(dz_r) + int'($urandom_range(0, 6)) - 3);
    end else begin
      v = base + sgn * (int'(ft_r) + int'($urandom_range(0, 6)) - 3);
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver: offers queued samples, holds valid until the transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      drv_valid = sample_valid;
      drv_data  = sample_mg;
      if (sample_fired) begin
        sample_fired = 1'b0;
        drv_valid    = 1'b0;
      end
      if (!drv_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_samples.size() > 0) begin
          drv_data  = pending_samples.pop_front();
          drv_valid = 1'b1;
          send_gap  = pick_gap();  // idle time after this transfer
        end
      end
      sample_valid <= drv_valid;
      sample_mg    <= drv_data;
    end
  end

  // ---------------------------------------------------------------------------
  // position receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      position_ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (pos_fired) begin
        pos_fired = 1'b0;
        recv_gap  = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      position_ready <= nxt_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each sample transfer, check each position transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        want_pos.push_back(track_position(sample_mg));
        accepted_cnt++;
        sample_fired = 1'b1;
      end
      if (position_valid && position_ready) begin
        pos_fired = 1'b1;
        if (want_pos.size() == 0) begin
          $error("position: no result expected, got %0d", position);
          fails++;
        end else begin
          want_now = want_pos.pop_front();
          checked_cnt++;
          if (position !== want_now) begin
            $error("position: expected %0d, actual %0d", want_now, position);
            fails++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_BIAS:      bias_r = val[SMP_W-1:0];
      REG_INVERT:    inv_r  = val[0];
      REG_ALPHA:     alpha_r = val[ALPHA_W-1:0];
      REG_DEAD_ZONE: dz_r   = val[DZ_W-1:0];
      REG_FULL_TILT: ft_r   = val[DZ_W-1:0];
      REG_POS_MIN:   pmin_r = val[POS_W-1:0];
      REG_POS_MAX:   pmax_r = val[POS_W-1:0];
      default: ;  // out-of-range index, dropped by the block
    endcase
    cfg_writes++;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // queue one sample; called just after a rising edge
  task automatic queue_sample(input logic signed [SMP_W-1:0] v);
    pending_samples.push_back(v);
    queued_total++;
  endtask

  // wait until every queued sample went through and every position came back
  task automatic drain();
    @(negedge clk);
    while (accepted_cnt != queued_total || want_pos.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic directed(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val,
                          input logic signed [SMP_W-1:0] s0, input logic signed [SMP_W-1:0] s1,
                          input int n);
    write_reg(idx, val);
    end_writes();
    @(posedge clk);
    if (n > 0) queue_sample(s0);
    if (n > 1) queue_sample(s1);
    drain();
  endtask

  // all seven registers for one random phase; phases 0..2 are fixed corners
  task automatic setup_phase(input int p);
    logic [CFG_WIDTH-1:0] b;
    logic                 iv;
    logic [ALPHA_W-1:0]   al;
    logic [DZ_W-1:0]      dzv, ftv;
    logic [POS_W-1:0]     lo, hi;
    case (p)
      0: begin  // reset values
        b = '0; iv = 1'b0; al = ALPHA_RST; dzv = DEAD_ZONE_RST; ftv = FULL_TILT_RST;
        lo = POS_MIN_RST; hi = POS_MAX_RST;
      end
      1: begin  // top of every range, alpha at one
        b = 16'h7FFF; iv = 1'b1; al = ALPHA_ONE; dzv = 15'h7FFF; ftv = 15'h7FFF;
        lo = 10'd1023; hi = 10'd1023;
      end
      2: begin  // bottom of every range
        b = 16'h8000; iv = 1'b0; al = '0; dzv = '0; ftv = '0; lo = '0; hi = '0;
      end
      default: begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: b = 16'(int'($urandom_range(0, 1200)) - 600);
          5, 6, 7:       b = 16'($urandom());
          8:             b = 16'h7FFF;
          default:       b = 16'h8000;
        endcase
        iv = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0: al = '0;
          1: al = ALPHA_ONE;
          2: al = 9'($urandom_range(257, 511));  // above one
          3: al = 9'd1;
          default: al = 9'($urandom_range(8, 200));
        endcase
        case ($urandom_range(0, 5))
          0: dzv = '0;
          1: dzv = 15'($urandom());
          default: dzv = 15'($urandom_range(0, 400));
        endcase
        case ($urandom_range(0, 5))
          0: ftv = '0;
          1: ftv = 15'h7FFF;
          2: ftv = dzv;  // no usable range, effective range of one
          default: ftv = 15'(int'(dzv) + int'($urandom_range(50, 3000)));
        endcase
        case ($urandom_range(0, 5))
          0: begin lo = 10'($urandom()); hi = 10'($urandom()); end  // either order
          1: begin lo = '0; hi = 10'd1023; end
          2: begin lo = 10'($urandom()); hi = lo; end
          default: begin lo = 10'($urandom_range(0, 500)); hi = 10'($urandom_range(512, 1023)); end
        endcase
      end
    endcase
    write_reg(REG_BIAS, b);
    write_reg(REG_INVERT, CFG_WIDTH'(iv));
    write_reg(REG_ALPHA, CFG_WIDTH'(al));
    write_reg(REG_DEAD_ZONE, CFG_WIDTH'(dzv));
    write_reg(REG_FULL_TILT, CFG_WIDTH'(ftv));
    write_reg(REG_POS_MIN, CFG_WIDTH'(lo));
    write_reg(REG_POS_MAX, CFG_WIDTH'(hi));
    end_writes();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: first sample loads the filter, then the sample extremes
    @(posedge clk);
    queue_sample(16'sd250);
    queue_sample(-16'sd32768);
    queue_sample(16'sd32767);
    queue_sample(-16'sd1);
    drain();

    // alpha of one so the dead zone and full tilt edges land exactly
    write_reg(REG_ALPHA, CFG_WIDTH'(ALPHA_ONE));
    end_writes();
    @(posedge clk);
    queue_sample(16'sd99);
    queue_sample(16'sd100);
    queue_sample(-16'sd100);
    queue_sample(16'sd1000);
    queue_sample(16'sd1001);
    queue_sample(-16'sd1000);
    drain();

    // bias subtraction saturating low, then high
    directed(REG_BIAS, 16'h7FFF, -16'sd32768, 16'sd0, 1);
    directed(REG_BIAS, 16'h8000, 16'sd32767, 16'sd0, 1);
    // negating the most negative corrected value
    write_reg(REG_BIAS, '0);
    directed(REG_INVERT, 16'd1, -16'sd32768, 16'sd0, 1);
    directed(REG_INVERT, 16'd0, 16'sd0, 16'sd0, 0);
    // alpha above one acts as one; alpha of zero freezes the filter
    directed(REG_ALPHA, 16'd511, 16'sd500, 16'sd0, 1);
    directed(REG_ALPHA, 16'd0, 16'sd700, 16'sd0, 1);
    // minimum above maximum: dead zone gives raw centre, else clamp to max
    write_reg(REG_ALPHA, CFG_WIDTH'(ALPHA_ONE));
    write_reg(REG_POS_MIN, 16'd900);
    directed(REG_POS_MAX, 16'd100, 16'sd50, 16'sd2000, 2);
    // dead zone above full tilt, effective range of one
    write_reg(REG_POS_MIN, '0);
    write_reg(REG_POS_MAX, 16'd1023);
    write_reg(REG_DEAD_ZONE, 16'd2000);
    directed(REG_FULL_TILT, 16'd1000, 16'sd2500, -16'sd2500, 2);
    // write past the last register changes nothing
    directed(REG_NONE, 16'hFFFF, 16'sd3000, 16'sd0, 1);

    // random phases; one with a long receiver hold-off, one with no idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      setup_phase(p);
      @(posedge clk);
      calm = (p == 5);
      if (p == 3) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) queue_sample(next_sample());
      drain();
      phases_run++;
    end
    @(posedge clk);
    calm = 1'b0;

    if (want_pos.size() != 0) begin
      $error("position: %0d results never arrived", want_pos.size());
      fails++;
    end
    $display("covered: %0d samples, %0d positions checked, %0d random phases, %0d register writes",
             accepted_cnt, checked_cnt, phases_run, cfg_writes);
    $display("covered: %0d long output hold-offs of %0d cycles, %0d failures",
             holds_done, HOLD_CYCLES, fails);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
